/* hw/rtl/epwd_pkg.sv */
// ----------------------------------------------------------------------------
// epwd_pkg
// Shared types and constants for the echo pulse width to distance block.
// ----------------------------------------------------------------------------
package epwd_pkg;

	localparam int unsigned OVF_W   = 6;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TICKS_W = OVF_W + COUNT_W;
	localparam int unsigned DIST_W  = 17;

	// request kinds
	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// capture polarity
	localparam logic POL_RISING  = 1'b0;
	localparam logic POL_FALLING = 1'b1;

	localparam logic [OVF_W-1:0]   OVF_MAX   = 6'h3F;
	localparam logic [COUNT_W-1:0] SAT_COUNT = 16'hFFFF;

	// floor(ticks*33/2000) == (ticks * DIST_MULT) >> DIST_SHIFT for ticks < 2^22
	// DIST_MULT = ceil(33 * 2^33 / 2000), rounding error 464/2000 per 2^33
	localparam int unsigned MULT_W     = 28;
	localparam int unsigned PROD_W     = TICKS_W + MULT_W;
	localparam int unsigned DIST_SHIFT = 33;
	localparam logic [MULT_W-1:0] DIST_MULT = 28'd141733921;

	typedef struct packed {
		logic               req_type;
		logic               overflow_event;
		logic               edge_event;
		logic [COUNT_W-1:0] captured_count;
	} req_t;

	typedef struct packed {
		logic              edge_select;
		logic              clear_counter;
		logic              measure_done;
		logic [DIST_W-1:0] distance;
	} rsp_t;

endpackage

/* hw/rtl/epwd_dist.sv */
// ----------------------------------------------------------------------------
// epwd_dist
// Converts timer ticks to distance with one constant reciprocal multiply.
// ----------------------------------------------------------------------------
module epwd_dist import epwd_pkg::*; (
	input  logic [TICKS_W-1:0] ticks,
	output logic [DIST_W-1:0]  distance
);

	logic [PROD_W-1:0] product;

	// ticks * 33 / 2000 as multiply and shift
	assign product  = {{MULT_W{1'b0}}, ticks} * {{TICKS_W{1'b0}}, DIST_MULT};
	assign distance = product[DIST_SHIFT +: DIST_W];

endmodule

/* hw/rtl/epwd_ctrl.sv */
// ----------------------------------------------------------------------------
// epwd_ctrl
// Measurement state: edge and overflow handling, read and restart, and the
// result word that each request produces.
// ----------------------------------------------------------------------------
module epwd_ctrl import epwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	output rsp_t rsp
);

	logic               done_q;
	logic               high_q;
	logic [OVF_W-1:0]   ovf_cnt_q;
	logic [COUNT_W-1:0] pulse_cnt_q;
	logic               pol_q;
	logic [DIST_W-1:0]  last_dist_q;

	logic               done_d;
	logic               high_d;
	logic [OVF_W-1:0]   ovf_cnt_d;
	logic [COUNT_W-1:0] pulse_cnt_d;
	logic               pol_d;
	logic [DIST_W-1:0]  last_dist_d;
	logic               clr;
	logic [DIST_W-1:0]  conv_dist;

	// distance of the finished measurement held in state
	epwd_dist u_dist (
		.ticks    ({ovf_cnt_q, pulse_cnt_q}),
		.distance (conv_dist)
	);

	// next state for the word in flight
	always_comb begin
		done_d      = done_q;
		high_d      = high_q;
		ovf_cnt_d   = ovf_cnt_q;
		pulse_cnt_d = pulse_cnt_q;
		pol_d       = pol_q;
		last_dist_d = last_dist_q;
		clr         = 1'b0;
		unique case (req.req_type)
			REQ_EVENT: begin
				if (!done_q) begin
					// overflow first, only while the pulse is high
					if (req.overflow_event && high_q) begin
						if (ovf_cnt_q == OVF_MAX) begin
							done_d      = 1'b1;
							pulse_cnt_d = SAT_COUNT;
						end else begin
							ovf_cnt_d = ovf_cnt_q + 1'b1;
						end
					end
					if (req.edge_event) begin
						if (high_q) begin
							// falling edge ends the pulse
							done_d      = 1'b1;
							pulse_cnt_d = req.captured_count;
							pol_d       = POL_RISING;
						end else begin
							// rising edge starts the pulse
							done_d      = 1'b0;
							ovf_cnt_d   = '0;
							pulse_cnt_d = '0;
							high_d      = 1'b1;
							clr         = 1'b1;
							pol_d       = POL_FALLING;
						end
					end
				end
			end
			REQ_READ: begin
				if (done_q) begin
					last_dist_d = conv_dist;
					done_d      = 1'b0;
					high_d      = 1'b0;
					ovf_cnt_d   = '0;
				end
			end
			default: begin
				clr = 1'b0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			high_q      <= 1'b0;
			ovf_cnt_q   <= '0;
			pulse_cnt_q <= '0;
			pol_q       <= POL_RISING;
			last_dist_q <= '0;
		end else if (fire) begin
			done_q      <= done_d;
			high_q      <= high_d;
			ovf_cnt_q   <= ovf_cnt_d;
			pulse_cnt_q <= pulse_cnt_d;
			pol_q       <= pol_d;
			last_dist_q <= last_dist_d;
		end
	end

	// result word reflects the state after this request
	assign rsp.edge_select   = pol_d;
	assign rsp.clear_counter = clr;
	assign rsp.measure_done  = done_d;
	assign rsp.distance      = last_dist_d;

	// a finished measurement always had its pulse start
	a_done_needs_high: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> high_q)
		else $error("measurement done without a started pulse");

	// overflows are only counted inside a pulse
	a_ovf_needs_high: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_cnt_q != '0) |-> high_q)
		else $error("overflow count nonzero outside a pulse");

	// a counter clear only starts a pulse that was not yet high
	a_clr_needs_low: assert property (@(posedge clk) disable iff (!arst_n)
		clr |-> !high_q)
		else $error("counter clear while the pulse is already high");

endmodule

/* hw/rtl/echo_pulse_width_to_distance.sv */
// ----------------------------------------------------------------------------
// echo_pulse_width_to_distance
// Path: an accepted request sits in the input register; its result word is
// registered into the result register when that register is free or drained.
// Throughput: one request per cycle while the result register drains; the
// state-to-result path through the distance multiplier sets the clock period.
// Reset: arst_n clears all measurement state and both valid flags.
// ----------------------------------------------------------------------------
module echo_pulse_width_to_distance import epwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic valid_s1;
	req_t req_s1;
	logic adv;
	logic fire;
	rsp_t rsp_d;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// stage 1 moves on when the result register is free or being drained
	assign adv       = !rsp_valid_q || rsp_ready;
	assign fire      = valid_s1 && adv;
	assign req_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	epwd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.rsp    (rsp_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// counter clear only comes with the switch to falling-edge capture
	a_clr_falling: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.clear_counter) |-> (rsp.edge_select == POL_FALLING))
		else $error("counter clear without falling-edge capture");

	// a pulse start never reports a finished measurement
	a_clr_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.clear_counter) |-> !rsp.measure_done)
		else $error("counter clear on a finished measurement");

	// a stalled word in stage 1 is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("stage 1 word lost while stalled");

endmodule
